[hdl/nmf_pkg.sv]
// Shared types and constants for the 3x3 neighbour-maximum filter.
// No dependencies; the top level, nmf_window and nmf_emit import it.
`timescale 1ns / 1ps

package nmf_pkg;

    // Fixed field widths of the stream and configuration ports; reset size
    localparam int IDX_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int SIZE_RESET = 4;

    // Bit positions of the result kinds in a pending mask, in output order.
    // Upper/lower is result row r-1 or r; left/right is column c-1 or c.
    localparam int RK_UL   = 0;
    localparam int RK_UR   = 1;
    localparam int RK_LL   = 2;
    localparam int RK_LR   = 3;
    localparam int N_KINDS = 4;

    // Position flags of one input item, worked out when it is accepted
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic last_row;
        logic last_col;
    } pos_flags_t;

endpackage

[hdl/neighbor_max_filter_3x3_top.sv]
// 3x3 neighbour-maximum filter over a square image streamed in raster order.
// Throughput: one item per cycle while the output is free and no item
// causes more than one result; an item closing a row or the frame causes up to
// four, which stall the input. Registers: stage one, window, output.
// Reset: position row 0, column 0, image size 4; the three line store banks
// are not cleared, rows not yet written in the frame are never used.
`timescale 1ns / 1ps

module neighbor_max_filter_3x3_top
    import nmf_pkg::*;
#(
    parameter int MAX_SIZE    = 1024,
    parameter int PIXEL_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [SIZE_W-1:0]                       cfg_wr_data,  // image_size
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((PIXEL_WIDTH+7)/8)*8-1:0]        s_tdata,      // pixel_value
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // out_row, out_col, max_value
    output logic [((2*IDX_W+PIXEL_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                                    m_tlast       // last_in_step
);

    localparam int PW     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int OUT_TW = ((2*IDX_W+PIXEL_WIDTH+7)/8)*8;
    localparam int RESET_SIDE = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;
    localparam logic [PW-1:0] RESET_LAST = PW'(RESET_SIDE - 1);
    localparam logic [PW-1:0] MAX_LAST   = PW'(MAX_SIZE - 1);

    // Input position and image size
    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [1:0]    bank_reg, bank_next;
    logic [PW-1:0] last_idx_reg, last_idx_next;
    logic [SIZE_W-1:0] cfg_m1;

    logic       accept;
    pos_flags_t flags_now;

    // Stage one: item waiting for its line store reads
    logic                          v1_reg;
    logic signed [PIXEL_WIDTH-1:0] pix1_reg;
    logic [PW-1:0]                 row1_reg;
    logic [PW-1:0]                 col1_reg;
    logic [1:0]                    bank1_reg;
    pos_flags_t                    flags1_reg;

    logic                          load;
    logic                          emit_ready;
    logic [PIXEL_WIDTH-1:0]        rd_data [0:2];
    logic signed [PIXEL_WIDTH-1:0] mid_raw;
    logic signed [PIXEL_WIDTH-1:0] top_raw;

    logic signed [PIXEL_WIDTH-1:0] col3_0, col3_1, col3_2;
    logic signed [PIXEL_WIDTH-1:0] bot2_0, bot2_1, bot2_2;
    logic signed [PIXEL_WIDTH-1:0] tb_1, tb_2, mid_1, mid_2;

    logic [IDX_W-1:0]              res_row;
    logic [IDX_W-1:0]              res_col;
    logic signed [PIXEL_WIDTH-1:0] res_max;

    assign accept   = s_tvalid && s_tready;
    assign load     = v1_reg && emit_ready;
    assign s_tready = !v1_reg || load;

    // Flags of the item at the current position
    always_comb
    begin
        flags_now.row_ge1  = (row_reg != '0);
        flags_now.row_ge2  = (row_reg != '0) && (row_reg != PW'(1));
        flags_now.col_ge1  = (col_reg != '0);
        flags_now.col_ge2  = (col_reg != '0) && (col_reg != PW'(1));
        flags_now.last_row = (row_reg == last_idx_reg);
        flags_now.last_col = (col_reg == last_idx_reg);
    end

    // Raster position advance; the bank index follows the row modulo three
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg + 1'b1;
        bank_next = bank_reg;
        if (flags_now.last_col)
        begin
            col_next = '0;
            if (flags_now.last_row)
            begin
                row_next  = '0;
                bank_next = 2'd0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
                case (bank_reg)
                    2'd0:    bank_next = 2'd1;
                    2'd1:    bank_next = 2'd2;
                    default: bank_next = 2'd0;
                endcase
            end
        end
    end

    // Effective side length less one: zero counts as one, large values clamp
    always_comb
    begin
        cfg_m1 = cfg_wr_data - 1'b1;
        if (cfg_wr_data == '0)
        begin
            last_idx_next = '0;
        end
        else if (int'(cfg_wr_data) > MAX_SIZE)
        begin
            last_idx_next = MAX_LAST;
        end
        else
        begin
            last_idx_next = PW'(cfg_m1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            bank_reg     <= 2'd0;
            last_idx_reg <= RESET_LAST;
        end
        else if (cfg_wr_en)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            bank_reg     <= 2'd0;
            last_idx_reg <= last_idx_next;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            bank_reg <= bank_next;
        end
    end

    // Line store: the new pixel goes to its row's bank while the two older
    // rows are read at the same column.
    for (genvar i = 0; i < 3; i++)
    begin : g_bank
        nmf_line_ram #(
            .DEPTH (MAX_SIZE),
            .WIDTH (PIXEL_WIDTH),
            .AW    (PW)
        ) u_ram (
            .clk   (clk),
            .we    (accept && (bank_reg == 2'(i))),
            .re    (accept),
            .addr  (col_reg),
            .wdata (s_tdata[PIXEL_WIDTH-1:0]),
            .rdata (rd_data[i])
        );
    end

    // Stage one registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (accept)
        begin
            v1_reg <= 1'b1;
        end
        else if (load)
        begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg   <= s_tdata[PIXEL_WIDTH-1:0];
            row1_reg   <= row_reg;
            col1_reg   <= col_reg;
            bank1_reg  <= bank_reg;
            flags1_reg <= flags_now;
        end
    end

    // Row above comes from the previous bank, two above from the next one
    always_comb
    begin
        case (bank1_reg)
            2'd0:
            begin
                mid_raw = rd_data[2];
                top_raw = rd_data[1];
            end
            2'd1:
            begin
                mid_raw = rd_data[0];
                top_raw = rd_data[2];
            end
            default:
            begin
                mid_raw = rd_data[1];
                top_raw = rd_data[0];
            end
        endcase
    end

    nmf_window #(
        .PIXEL_WIDTH (PIXEL_WIDTH)
    ) u_window (
        .clk     (clk),
        .load    (load),
        .flags   (flags1_reg),
        .pix     (pix1_reg),
        .mid_raw (mid_raw),
        .top_raw (top_raw),
        .col3_0  (col3_0),
        .col3_1  (col3_1),
        .col3_2  (col3_2),
        .bot2_0  (bot2_0),
        .bot2_1  (bot2_1),
        .bot2_2  (bot2_2),
        .tb_1    (tb_1),
        .tb_2    (tb_2),
        .mid_1   (mid_1),
        .mid_2   (mid_2)
    );

    nmf_emit #(
        .PIXEL_WIDTH (PIXEL_WIDTH),
        .PW          (PW)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .flags      (flags1_reg),
        .row_in     (row1_reg),
        .col_in     (col1_reg),
        .col3_0     (col3_0),
        .col3_1     (col3_1),
        .col3_2     (col3_2),
        .bot2_0     (bot2_0),
        .bot2_1     (bot2_1),
        .bot2_2     (bot2_2),
        .tb_1       (tb_1),
        .tb_2       (tb_2),
        .mid_1      (mid_1),
        .mid_2      (mid_2),
        .load_ready (emit_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_row    (res_row),
        .out_col    (res_col),
        .out_max    (res_max),
        .out_last   (m_tlast)
    );

    assign m_tdata = OUT_TW'({res_max, res_col, res_row});

endmodule

[hdl/nmf_line_ram.sv]
// Line store bank: one image row of pixels, synchronous read and write.
// Depends on nothing; the top level instantiates one bank per stored row.
`timescale 1ns / 1ps

module nmf_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents when the same entry is written
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/nmf_window.sv]
// Column reduction and three-column sliding window of partial maxima.
// Depends on nmf_pkg; fed by the stage-one registers of the top level.
`timescale 1ns / 1ps

module nmf_window
    import nmf_pkg::*;
#(
    parameter int PIXEL_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          load,
    input  pos_flags_t                    flags,
    input  logic signed [PIXEL_WIDTH-1:0] pix,
    input  logic signed [PIXEL_WIDTH-1:0] mid_raw,
    input  logic signed [PIXEL_WIDTH-1:0] top_raw,
    output logic signed [PIXEL_WIDTH-1:0] col3_0,
    output logic signed [PIXEL_WIDTH-1:0] col3_1,
    output logic signed [PIXEL_WIDTH-1:0] col3_2,
    output logic signed [PIXEL_WIDTH-1:0] bot2_0,
    output logic signed [PIXEL_WIDTH-1:0] bot2_1,
    output logic signed [PIXEL_WIDTH-1:0] bot2_2,
    output logic signed [PIXEL_WIDTH-1:0] tb_1,
    output logic signed [PIXEL_WIDTH-1:0] tb_2,
    output logic signed [PIXEL_WIDTH-1:0] mid_1,
    output logic signed [PIXEL_WIDTH-1:0] mid_2
);

    localparam logic signed [PIXEL_WIDTH-1:0] PIX_MIN = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

    logic signed [PIXEL_WIDTH-1:0] top_v;
    logic signed [PIXEL_WIDTH-1:0] mid_v;
    logic signed [PIXEL_WIDTH-1:0] new_tb;
    logic signed [PIXEL_WIDTH-1:0] new_bot2;
    logic signed [PIXEL_WIDTH-1:0] new_col3;

    logic signed [PIXEL_WIDTH-1:0] col3_0_reg, col3_1_reg, col3_2_reg;
    logic signed [PIXEL_WIDTH-1:0] bot2_0_reg, bot2_1_reg, bot2_2_reg;
    logic signed [PIXEL_WIDTH-1:0] tb_1_reg, tb_2_reg;
    logic signed [PIXEL_WIDTH-1:0] mid_1_reg, mid_2_reg;

    // Rows above the image read as the most negative value, which is
    // neutral for a maximum.
    always_comb
    begin
        top_v    = flags.row_ge2 ? top_raw : PIX_MIN;
        mid_v    = flags.row_ge1 ? mid_raw : PIX_MIN;
        new_tb   = (top_v > pix) ? top_v : pix;
        new_bot2 = (mid_v > pix) ? mid_v : pix;
        new_col3 = (new_tb > mid_v) ? new_tb : mid_v;
    end

    // Shift a new column in; columns left of the image are neutralised
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col3_2_reg <= new_col3;
            bot2_2_reg <= new_bot2;
            tb_2_reg   <= new_tb;
            mid_2_reg  <= mid_v;
            if (!flags.col_ge1)
            begin
                col3_0_reg <= PIX_MIN;
                col3_1_reg <= PIX_MIN;
                bot2_0_reg <= PIX_MIN;
                bot2_1_reg <= PIX_MIN;
                tb_1_reg   <= PIX_MIN;
                mid_1_reg  <= PIX_MIN;
            end
            else
            begin
                col3_1_reg <= col3_2_reg;
                bot2_1_reg <= bot2_2_reg;
                tb_1_reg   <= tb_2_reg;
                mid_1_reg  <= mid_2_reg;
                col3_0_reg <= flags.col_ge2 ? col3_1_reg : PIX_MIN;
                bot2_0_reg <= flags.col_ge2 ? bot2_1_reg : PIX_MIN;
            end
        end
    end

    assign col3_0 = col3_0_reg;
    assign col3_1 = col3_1_reg;
    assign col3_2 = col3_2_reg;
    assign bot2_0 = bot2_0_reg;
    assign bot2_1 = bot2_1_reg;
    assign bot2_2 = bot2_2_reg;
    assign tb_1   = tb_1_reg;
    assign tb_2   = tb_2_reg;
    assign mid_1  = mid_1_reg;
    assign mid_2  = mid_2_reg;

endmodule

[hdl/nmf_emit.sv]
// Result sequencer: emits up to four results per window, one per cycle while
// the output is not stalled, through an output register. Depends on nmf_pkg and the nmf_window data.
`timescale 1ns / 1ps

module nmf_emit
    import nmf_pkg::*;
#(
    parameter int PIXEL_WIDTH = 16,
    parameter int PW          = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  pos_flags_t                    flags,
    input  logic [PW-1:0]                 row_in,
    input  logic [PW-1:0]                 col_in,
    input  logic signed [PIXEL_WIDTH-1:0] col3_0,
    input  logic signed [PIXEL_WIDTH-1:0] col3_1,
    input  logic signed [PIXEL_WIDTH-1:0] col3_2,
    input  logic signed [PIXEL_WIDTH-1:0] bot2_0,
    input  logic signed [PIXEL_WIDTH-1:0] bot2_1,
    input  logic signed [PIXEL_WIDTH-1:0] bot2_2,
    input  logic signed [PIXEL_WIDTH-1:0] tb_1,
    input  logic signed [PIXEL_WIDTH-1:0] tb_2,
    input  logic signed [PIXEL_WIDTH-1:0] mid_1,
    input  logic signed [PIXEL_WIDTH-1:0] mid_2,
    output logic                          load_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [IDX_W-1:0]              out_row,
    output logic [IDX_W-1:0]              out_col,
    output logic signed [PIXEL_WIDTH-1:0] out_max,
    output logic                          out_last
);

    localparam logic signed [PIXEL_WIDTH-1:0] PIX_MIN = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

    logic                 busy_reg;
    logic [N_KINDS-1:0]   pend_reg;
    logic [PW-1:0]        row_reg;
    logic [PW-1:0]        col_reg;

    logic                          m_valid_reg;
    logic [IDX_W-1:0]              m_row_reg;
    logic [IDX_W-1:0]              m_col_reg;
    logic signed [PIXEL_WIDTH-1:0] m_max_reg;
    logic                          m_last_reg;

    logic [N_KINDS-1:0]            pend_in;
    logic [N_KINDS-1:0]            sel;
    logic [N_KINDS-1:0]            pend_rest;
    logic                          out_free;
    logic                          emit;
    logic                          done;
    logic signed [PIXEL_WIDTH-1:0] cand_a;
    logic signed [PIXEL_WIDTH-1:0] cand_b;
    logic signed [PIXEL_WIDTH-1:0] cand_c;
    logic signed [PIXEL_WIDTH-1:0] max_ab;
    logic signed [PIXEL_WIDTH-1:0] max_all;
    logic                          res_lower;
    logic                          res_right;
    logic [PW-1:0]                 res_row;
    logic [PW-1:0]                 res_col;

    // Results caused by the incoming item
    always_comb
    begin
        pend_in          = '0;
        pend_in[RK_UL]   = flags.row_ge1 && flags.col_ge1;
        pend_in[RK_UR]   = flags.row_ge1 && flags.last_col;
        pend_in[RK_LL]   = flags.last_row && flags.col_ge1;
        pend_in[RK_LR]   = flags.last_row && flags.last_col;
    end

    // Handshake of the sequencer: lowest pending kind goes first
    always_comb
    begin
        sel        = pend_reg & (~pend_reg + 1'b1);
        pend_rest  = pend_reg & ~sel;
        out_free   = !m_valid_reg || out_ready;
        emit       = busy_reg && (pend_reg != '0) && out_free;
        done       = busy_reg && ((pend_reg == '0) || (emit && (pend_rest == '0)));
        load_ready = !busy_reg || done;
    end

    // Candidates of the selected result; the centre is left out of each
    always_comb
    begin
        cand_a    = bot2_1;
        cand_b    = mid_2;
        cand_c    = PIX_MIN;
        res_lower = 1'b1;
        res_right = 1'b1;
        if (sel[RK_UL])
        begin
            cand_a    = col3_0;
            cand_b    = col3_2;
            cand_c    = tb_1;
            res_lower = 1'b0;
            res_right = 1'b0;
        end
        else if (sel[RK_UR])
        begin
            cand_a    = col3_1;
            cand_b    = tb_2;
            cand_c    = PIX_MIN;
            res_lower = 1'b0;
        end
        else if (sel[RK_LL])
        begin
            cand_a    = bot2_0;
            cand_b    = bot2_2;
            cand_c    = mid_1;
            res_right = 1'b0;
        end
        max_ab  = (cand_a > cand_b) ? cand_a : cand_b;
        max_all = (max_ab > cand_c) ? max_ab : cand_c;
        res_row = res_lower ? row_reg : row_reg - 1'b1;
        res_col = res_right ? col_reg : col_reg - 1'b1;
    end

    // Sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            pend_reg <= pend_in;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
            pend_reg <= '0;
        end
        else if (emit)
        begin
            pend_reg <= pend_rest;
        end
    end

    // Position of the item that loaded the window
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= row_in;
            col_reg <= col_in;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_row_reg  <= IDX_W'(res_row);
            m_col_reg  <= IDX_W'(res_col);
            m_max_reg  <= max_all;
            m_last_reg <= (pend_rest == '0);
        end
    end

    assign out_valid = m_valid_reg;
    assign out_row   = m_row_reg;
    assign out_col   = m_col_reg;
    assign out_max   = m_max_reg;
    assign out_last  = m_last_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench for neighbor_max_filter_3x3_top: random pixel streams over many image
// sizes, checked item by item against a behavioural predictor of the filter.
// Depends on nmf_pkg and the top level of the block only.
`timescale 1ns / 1ps

module testbench;
    import nmf_pkg::*;

    localparam int PIX_W     = 16;
    localparam int MAX_SIDE  = 1024;
    localparam int IDLE_MAX  = 1000;
    localparam int SETTLE    = 8;
    localparam int RAND_GOAL = 412;

    // One filter result as the block should present it
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [PIX_W-1:0] value;
        logic                    last;
    } nmf_result_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]       cfg_wr_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [15:0]             s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [39:0]             m_tdata;
    logic                    m_tlast;

    // Stimulus and prediction state
    logic [PIX_W-1:0]        pixel_queue[$];
    nmf_result_t             expected_results[$];
    logic signed [PIX_W-1:0] pixel_store[0:3*MAX_SIDE-1];
    logic [SIZE_W-1:0]       image_size_reg = SIZE_W'(SIZE_RESET);
    int                      cur_row = 0;
    int                      cur_col = 0;
    int                      issued_count = 0;
    int                      accepted_count = 0;
    int                      error_count = 0;
    int                      idle_cycles = 0;
    int                      burst_left = 1;
    int                      gap_left = 0;
    logic [15:0]             ready_pattern = 16'hffff;
    int                      pattern_age = 0;

    neighbor_max_filter_3x3_top #(
        .MAX_SIZE    (MAX_SIDE),
        .PIXEL_WIDTH (PIX_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Maximum of the in-image neighbours of (r, c), centre excluded
    function automatic logic signed [PIX_W-1:0] neighbour_max(int r, int c, int side);
        logic signed [PIX_W-1:0] best;
        int                      rr;
        int                      cc;
        best = {1'b1, {(PIX_W-1){1'b0}}};
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = r + dr;
                cc = c + dc;
                if ((dr == 0 && dc == 0) || rr < 0 || cc < 0 || rr >= side || cc >= side)
                    continue;
                if (pixel_store[(rr % 3) * MAX_SIDE + cc] > best)
                    best = pixel_store[(rr % 3) * MAX_SIDE + cc];
            end
        end
        return best;
    endfunction

    // Store one accepted pixel and queue every result that it completes
    task automatic take_pixel(input logic signed [PIX_W-1:0] px);
        int          side;
        int          rows[$];
        int          cols[$];
        nmf_result_t res;
        side = (image_size_reg == 0) ? 1 :
               ((image_size_reg > MAX_SIDE) ? MAX_SIDE : int'(image_size_reg));
        if (cur_row >= side || cur_col >= side)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        pixel_store[(cur_row % 3) * MAX_SIDE + cur_col] = px;
        if (cur_row >= 1)
            rows.push_back(cur_row - 1);
        if (cur_row == side - 1)
            rows.push_back(cur_row);
        if (cur_col >= 1)
            cols.push_back(cur_col - 1);
        if (cur_col == side - 1)
            cols.push_back(cur_col);
        foreach (rows[a])
        begin
            foreach (cols[b])
            begin
                res.row   = IDX_W'(rows[a]);
                res.col   = IDX_W'(cols[b]);
                res.value = neighbour_max(rows[a], cols[b], side);
                res.last  = (a == rows.size() - 1) && (b == cols.size() - 1);
                expected_results.push_back(res);
            end
        end
        // Advance the raster position, wrapping at the end of the frame
        if (cur_col + 1 < side)
            cur_col = cur_col + 1;
        else
        begin
            cur_col = 0;
            cur_row = (cur_row + 1 < side) ? cur_row + 1 : 0;
        end
    endtask

    // Pixel values with extremes and near-ties mixed into the random ones
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] extremes[4];
        int               pick;
        extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return extremes[$urandom_range(0, 3)];
        else if (pick < 3)
            return PIX_W'($urandom_range(0, 8) - 4);
        return PIX_W'($urandom);
    endfunction

    task automatic queue_pixel(input logic [PIX_W-1:0] px);
        pixel_queue.push_back(px);
        issued_count++;
    endtask

    // Wait until every item is taken and every result seen, then let the pipeline settle
    task automatic drain_block();
        do
            @(posedge clk);
        while (accepted_count != issued_count || expected_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_image_size(input int value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= SIZE_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (gap_left > 0 || pixel_queue.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_queue.pop_front();
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver: a rotating stall pattern, renewed whenever pattern_age wraps to zero
    always @(posedge clk)
    begin
        if (pattern_age == 0)
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
        pattern_age = (pattern_age + 1) % 64;
        m_tready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    // Prediction on accepted items, checking of accepted results, and the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                image_size_reg = cfg_wr_data;
                cur_row = 0;
                cur_col = 0;
            end
            if (s_tvalid && s_tready)
            begin
                take_pixel(s_tdata);
                accepted_count++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result row %0d col %0d", m_tdata[9:0], m_tdata[19:10]);
                    error_count++;
                end
                else
                begin
                    nmf_result_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (m_tdata[9:0] !== exp_res.row)
                    begin
                        $error("out_row: expected %0d, got %0d", exp_res.row, m_tdata[9:0]);
                        error_count++;
                    end
                    if (m_tdata[19:10] !== exp_res.col)
                    begin
                        $error("out_col: expected %0d, got %0d", exp_res.col, m_tdata[19:10]);
                        error_count++;
                    end
                    if (m_tdata[35:20] !== exp_res.value)
                    begin
                        $error("max_value: expected %0d, got %0d",
                               exp_res.value, $signed(m_tdata[35:20]));
                        error_count++;
                    end
                    if (m_tlast !== exp_res.last)
                    begin
                        $error("last_in_step: expected %0b, got %0b", exp_res.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("FAIL neighbor_max_filter_3x3_top");
                $finish;
            end
        end
    end

    // Stimulus: directed frames first, then random phases over many image sizes, then large sizes
    initial
    begin
        logic [PIX_W-1:0] directed_pixels[16];
        int               random_items;
        int               side;
        int               count;
        int               pick;
        directed_pixels = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff,
                            16'h0001, 16'hfffe, 16'h5555, 16'haaaa,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h7fff, 16'h8001, 16'h7ffe, 16'h4000};
        random_items = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size of four: one full frame plus the start of the next
        foreach (directed_pixels[k])
            queue_pixel(directed_pixels[k]);
        queue_pixel(16'h7fff);
        queue_pixel(16'h8000);
        drain_block();
        // A size of zero acts as one: no neighbours at all
        write_image_size(0);
        queue_pixel(16'h7fff);
        queue_pixel(16'h0000);
        drain_block();
        // Two by two: one full frame
        write_image_size(2);
        queue_pixel(16'h8000);
        queue_pixel(16'h7fff);
        queue_pixel(16'hffff);
        queue_pixel(16'h0000);
        drain_block();

        // Random phases, mostly small images so that frames complete often
        while (random_items < RAND_GOAL)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                side = $urandom_range(2, 9);
            else if (pick < 8)
                side = $urandom_range(10, 40);
            else
                side = $urandom_range(0, 3);
            count = (side < 2) ? $urandom_range(1, 6) : $urandom_range(1, 2 * side * side + 3);
            if (count > 90)
                count = 90;
            if (count > RAND_GOAL - random_items)
                count = RAND_GOAL - random_items;
            write_image_size(side);
            repeat (count) queue_pixel(random_pixel());
            random_items += count;
            drain_block();
        end

        // Large sizes: above the limit saturates, then the limit, then the widest field value
        write_image_size(1025);
        repeat (5) queue_pixel(random_pixel());
        drain_block();
        write_image_size(MAX_SIDE);
        repeat (3) queue_pixel(random_pixel());
        drain_block();
        write_image_size((1 << SIZE_W) - 1);
        repeat (6) queue_pixel(random_pixel());
        drain_block();
        // Back to a small image after the large one
        write_image_size(3);
        repeat (20) queue_pixel(random_pixel());
        drain_block();

        if (error_count == 0)
            $display("PASS neighbor_max_filter_3x3_top");
        else
            $display("FAIL neighbor_max_filter_3x3_top");
        $finish;
    end

endmodule
